// File: rtl/twmf_pkg.sv
// Shared types and constants of the trimmed window mean filter.
package twmf_pkg;

  localparam int SAMPLE_W = 12;
  localparam int AXES     = 3;
  localparam int TDATA_W  = ((AXES * SAMPLE_W + 7) / 8) * 8;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef enum logic [1:0] {
    RED_IDLE,
    RED_SUM,
    RED_MUL,
    RED_DONE
  } red_state_e;

endpackage

// File: rtl/twmf_sorter.sv
// One axis of the window: registers kept in ascending order, one insertion per word.
module twmf_sorter #(
  parameter int WINDOW_SIZE = 12
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [$clog2(WINDOW_SIZE)-1:0]         fill_i,
  input  twmf_pkg::sample_t                      sample_i,
  output twmf_pkg::sample_t [WINDOW_SIZE-1:0]    win_next_o
);
  import twmf_pkg::*;

  localparam int FW = $clog2(WINDOW_SIZE);

  sample_t [WINDOW_SIZE-1:0] win_q;
  sample_t [WINDOW_SIZE-1:0] win_d;
  logic    [WINDOW_SIZE-1:0] gt;

  for (genvar i = 0; i < WINDOW_SIZE; i++) begin : g_cell
    assign gt[i] = $signed(win_q[i]) > $signed(sample_i);

    always_comb begin
      win_d[i] = win_q[i];
      if ((fill_i > FW'(i) && gt[i]) || fill_i == FW'(i)) begin
        win_d[i] = sample_i;
        if (i > 0) begin
          // entry below is still larger: move it up one place
          if (gt[(i > 0) ? i - 1 : 0]) begin
            win_d[i] = win_q[(i > 0) ? i - 1 : 0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      win_q <= win_d;
    end
  end

  assign win_next_o = win_d;

endmodule

// File: rtl/twmf_reduce.sv
// Snapshot of the trimmed middle, serial sum, reciprocal scaling and result register.
module twmf_reduce #(
  parameter int WINDOW_SIZE = 12,
  parameter int TRIM        = 3
) (
  input  logic                                                        clk_i,
  input  logic                                                        rst_ni,
  input  logic                                                        load_i,
  input  twmf_pkg::sample_t [twmf_pkg::AXES-1:0][WINDOW_SIZE-1:0]     win_i,
  output logic                                                        idle_o,
  output logic                                                        m_valid_o,
  input  logic                                                        m_ready_i,
  output twmf_pkg::sample_t [twmf_pkg::AXES-1:0]                      mean_o
);
  import twmf_pkg::*;

  localparam int  KEEP_I   = WINDOW_SIZE - 2 * TRIM;
  localparam bit  HAS_KEEP = KEEP_I > 0;
  localparam int  KEEP     = HAS_KEEP ? KEEP_I : 1;
  localparam int  CNT_W    = (KEEP > 1) ? $clog2(KEEP) : 1;
  localparam int  SUM_W    = SAMPLE_W + 1 + $clog2(KEEP);
  localparam int  SHIFT    = SUM_W + $clog2(KEEP);
  localparam int  REC_W    = SUM_W + 2;
  localparam int  PROD_W   = SUM_W + REC_W;
  localparam logic [REC_W-1:0] RECIP =
    REC_W'(((64'd1 << SHIFT) + 64'(KEEP) - 64'd1) / 64'(KEEP));
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(KEEP - 1);

  red_state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  sample_t [AXES-1:0][KEEP-1:0]          snap_q;
  logic signed [AXES-1:0][SUM_W-1:0]     acc_q;
  logic [AXES-1:0][PROD_W-1:0]           prod_q;
  logic [AXES-1:0]                       neg_q;
  sample_t [AXES-1:0]                    mean_q;

  assign out_free = !out_valid_q || m_ready_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !m_ready_i;
    unique case (state_q)
      RED_IDLE: begin
        cnt_d = '0;
        if (load_i) begin
          state_d = HAS_KEEP ? RED_SUM : RED_DONE;
        end
      end
      RED_SUM: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == LAST_CNT) begin
          state_d = RED_MUL;
        end
      end
      RED_MUL: begin
        state_d = RED_DONE;
      end
      RED_DONE: begin
        // hold until the result register is free
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = RED_IDLE;
        end
      end
      default: state_d = RED_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= RED_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  for (genvar a = 0; a < AXES; a++) begin : g_axis
    logic [SUM_W-1:0] mag;
    sample_t          quot;

    assign mag  = acc_q[a][SUM_W-1] ? SUM_W'(-acc_q[a]) : SUM_W'(acc_q[a]);
    assign quot = prod_q[a][SHIFT +: SAMPLE_W];

    always_ff @(posedge clk_i) begin
      if (state_q == RED_IDLE && load_i) begin
        acc_q[a] <= '0;
        for (int k = 0; k < KEEP; k++) begin
          snap_q[a][k] <= HAS_KEEP ? win_i[a][(TRIM + k) % WINDOW_SIZE] : '0;
        end
      end else if (state_q == RED_SUM) begin
        acc_q[a] <= acc_q[a] + SUM_W'(snap_q[a][0]);
        for (int k = 0; k < KEEP - 1; k++) begin
          snap_q[a][k] <= snap_q[a][k+1];
        end
      end
      if (state_q == RED_MUL) begin
        prod_q[a] <= PROD_W'(mag) * PROD_W'(RECIP);
        neg_q[a]  <= acc_q[a][SUM_W-1];
      end
      if (state_q == RED_DONE && out_free) begin
        if (!HAS_KEEP) begin
          mean_q[a] <= '0;
        end else begin
          mean_q[a] <= neg_q[a] ? sample_t'(-quot) : quot;
        end
      end
    end
  end

  assign idle_o    = state_q == RED_IDLE;
  assign m_valid_o = out_valid_q;
  assign mean_o    = mean_q;

  a_load_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> state_q == RED_IDLE)
    else $error("snapshot loaded while reduction busy");

  a_rise_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == RED_DONE)
    else $error("result raised outside the done step");

  a_done_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == RED_DONE && !out_free |=> state_q == RED_DONE && out_valid_q)
    else $error("pending result dropped while output stalled");

endmodule

// File: rtl/trimmed_window_mean_filter.sv
// Top level of the trimmed window mean filter for three-axis accelerometer words.
// Throughput: one input word per cycle. The word that closes a window waits only if the
// previous result is still in reduction (snapshot, serial sum over KEEP samples, KEEP being
// WINDOW_SIZE - 2*TRIM, reciprocal scaling, done step) or the output register is not taken.
// The mean of a window passes the serial sum, the reciprocal scaling and the result register.
// Reset: rst_ni low clears the fill count, the reduction state and the output valid.
module trimmed_window_mean_filter #(
  parameter int WINDOW_SIZE = 12,
  parameter int TRIM        = 3
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // slave side: one sample word
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [twmf_pkg::TDATA_W-1:0]   s_axis_tdata_i,   // accel_x, accel_y, accel_z, zero pad
  // master side: one mean word
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [twmf_pkg::TDATA_W-1:0]   m_axis_tdata_o    // mean_x, mean_y, mean_z, zero pad
);
  import twmf_pkg::*;

  localparam int FW = $clog2(WINDOW_SIZE);
  localparam logic [FW-1:0] FILL_LAST = FW'(WINDOW_SIZE - 1);
  localparam int PAD_W = TDATA_W - AXES * SAMPLE_W;

  logic [FW-1:0] fill_q, fill_d;
  logic          accept;
  logic          closing;
  logic          red_idle;

  sample_t [AXES-1:0]                  sample;
  sample_t [AXES-1:0][WINDOW_SIZE-1:0] win_next;
  sample_t [AXES-1:0]                  mean;

  // Unpack the three axis fields from the word.
  for (genvar a = 0; a < AXES; a++) begin : g_unpack
    assign sample[a] = s_axis_tdata_i[a*SAMPLE_W +: SAMPLE_W];
  end

  // The closing word needs a free reduction unit to take the snapshot; all
  // other words only shift the sorted registers and are always taken.
  assign closing         = fill_q == FILL_LAST;
  assign s_axis_tready_o = !closing || red_idle;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // Advance the fill count, wrap to empty once the window is full.
  always_comb begin
    fill_d = fill_q;
    if (accept) begin
      fill_d = closing ? '0 : fill_q + FW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  // One sorted row of registers per axis; insertion happens in the cycle of acceptance.
  for (genvar a = 0; a < AXES; a++) begin : g_sort
    twmf_sorter #(
      .WINDOW_SIZE (WINDOW_SIZE)
    ) u_sorter (
      .clk_i      (clk_i),
      .we_i       (accept),
      .fill_i     (fill_q),
      .sample_i   (sample[a]),
      .win_next_o (win_next[a])
    );
  end

  // The closing word loads its freshly sorted window straight into the snapshot.
  twmf_reduce #(
    .WINDOW_SIZE (WINDOW_SIZE),
    .TRIM        (TRIM)
  ) u_reduce (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (accept && closing),
    .win_i     (win_next),
    .idle_o    (red_idle),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .mean_o    (mean)
  );

  assign m_axis_tdata_o = {PAD_W'(0), mean[2], mean[1], mean[0]};

  a_fill_wrap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && closing |=> fill_q == '0)
    else $error("fill count did not wrap after the closing word");

endmodule

// File: verif/trimmed_window_mean_filter_test.sv
// Self-checking testbench for the trimmed window mean filter: random stream with stalls.
`timescale 1ns / 1ps

module trimmed_window_mean_filter_test;
  import twmf_pkg::*;

  localparam int WINDOW_SIZE = 12;
  localparam int TRIM        = 3;
  // middle elements that survive the trim on each axis
  localparam int KEEP        = WINDOW_SIZE - 2 * TRIM;
  // closing word to mean word, plus margin for the output register
  localparam int SETTLE      = KEEP + 2 + 16;
  localparam int LIMIT       = 200_000;
  localparam int RANDOM_WORDS = 372;
  // the sender drains all pending means before this random word
  localparam int DRAIN_AT    = 200;
  // accepted-word span in which neither side idles
  localparam int CALM_FIRST  = 150;
  localparam int CALM_LAST   = 260;

  // one sample or one mean word; x sits in the low bits of tdata
  typedef struct packed {
    sample_t z;
    sample_t y;
    sample_t x;
  } triple_t;

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               s_vld  = 1'b0;
  logic               s_axis_tready_o;
  logic [TDATA_W-1:0] s_data = '0;
  logic               m_axis_tvalid_o;
  logic               m_rdy  = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata_o;

  logic [TDATA_W-1:0] sample_q[$];  // words waiting for the driver
  triple_t            mean_q[$];    // means the block still owes
  sample_t            win [AXES][WINDOW_SIZE];
  int                 fill = 0;
  int                 words_in = 0;
  int                 mismatches = 0;
  int                 cycle_count = 0;
  logic               calm;

  trimmed_window_mean_filter #(
    .WINDOW_SIZE(WINDOW_SIZE),
    .TRIM       (TRIM)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_vld),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_data),          // accel_x, accel_y, accel_z, zero pad
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_rdy),
    .m_axis_tdata_o (m_axis_tdata_o)   // mean_x, mean_y, mean_z, zero pad
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  assign calm = (words_in >= CALM_FIRST) && (words_in < CALM_LAST);

  // Sum the kept middle of one sorted axis and divide, truncating toward zero.
  function automatic sample_t window_mean(int a);
    int sum;
    int k;
    sum = 0;
    if (KEEP <= 0) return '0;
    for (k = TRIM; k < TRIM + KEEP; k++) sum += int'(win[a][k]);
    return sample_t'(sum / KEEP);
  endfunction

  // Insert one accepted word into the sorted windows; queue a mean once full.
  function automatic void absorb_sample(triple_t t);
    sample_t v [AXES];
    triple_t m;
    int      pos;
    v[0] = t.x;
    v[1] = t.y;
    v[2] = t.z;
    for (int a = 0; a < AXES; a++) begin
      pos = fill;
      // shift larger entries up one slot, keep ties in arrival order
      while (pos > 0 && win[a][pos-1] > v[a]) begin
        win[a][pos] = win[a][pos-1];
        pos--;
      end
      win[a][pos] = v[a];
    end
    fill++;
    if (fill == WINDOW_SIZE) begin
      m.x = window_mean(0);
      m.y = window_mean(1);
      m.z = window_mean(2);
      mean_q.push_back(m);
      fill = 0;
    end
  endfunction

  function automatic logic [TDATA_W-1:0] pack_word(sample_t x, sample_t y, sample_t z);
    triple_t t;
    t.x = x;
    t.y = y;
    t.z = z;
    return TDATA_W'(t);
  endfunction

  // Draw one axis value: full range, near zero, near the rails, or near a drifting level.
  function automatic sample_t draw_axis(int level);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) return sample_t'($urandom_range(4095));
    if (r < 60) return sample_t'(int'($urandom_range(16)) - 8);
    if (r < 75) begin
      if ($urandom_range(1)) return sample_t'(2047 - int'($urandom_range(3)));
      return sample_t'(-2048 + int'($urandom_range(3)));
    end
    return sample_t'(level + int'($urandom_range(40)) - 20);
  endfunction

  // Driver: hold the word until taken, then advance or idle at random.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_vld <= 1'b0;
    end else begin
      if (s_vld && s_axis_tready_o) begin
        absorb_sample(triple_t'(s_data[AXES*SAMPLE_W-1:0]));
        words_in <= words_in + 1;
      end
      if (!s_vld || s_axis_tready_o) begin
        if (sample_q.size() > 0 && (calm || $urandom_range(99) >= 15)) begin
          s_vld  <= 1'b1;
          s_data <= sample_q.pop_front();
        end else begin
          s_vld <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each taken mean word against the oldest owed mean.
  always @(posedge clk_i) begin
    triple_t got;
    triple_t want;
    if (!rst_ni) begin
      m_rdy <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_rdy) begin
        got = triple_t'(m_axis_tdata_o[AXES*SAMPLE_W-1:0]);
        if (mean_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected mean word x=%0d y=%0d z=%0d", got.x, got.y, got.z);
        end else begin
          want = mean_q.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.z !== want.z) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mean mismatch: expected x=%0d y=%0d z=%0d, got x=%0d y=%0d z=%0d",
                       want.x, want.y, want.z, got.x, got.y, got.z);
          end
        end
      end
      m_rdy <= calm || ($urandom_range(99) >= 15);
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("trimmed_window_mean_filter test failed");
      $finish;
    end
  end

  // Stimulus and end of run.
  initial begin
    int level [AXES];
    sample_t rail [WINDOW_SIZE];
    rail = '{-2048, 2047, -2048, 2047, 0, -1, 1, -2047, 2046, 1024, -1024, 0};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Rails and sign boundaries; z lands on a negative fraction to test truncation.
    for (int i = 0; i < WINDOW_SIZE; i++)
      sample_q.push_back(pack_word(rail[i], rail[WINDOW_SIZE-1-i], sample_t'(-(i % 4) - 1)));
    // Equal values: all-equal x and y, z made of two tied groups.
    for (int i = 0; i < WINDOW_SIZE; i++)
      sample_q.push_back(pack_word(sample_t'(2047), sample_t'(-2048),
                                   (i % 2) ? sample_t'(3) : sample_t'(-3)));

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % WINDOW_SIZE == 0)
        for (int a = 0; a < AXES; a++) level[a] = int'($urandom_range(4000)) - 2000;
      if (i == DRAIN_AT) begin
        // hold the sender until every owed mean has come back
        while (sample_q.size() > 0 || s_vld || mean_q.size() > 0) @(posedge clk_i);
      end
      sample_q.push_back(pack_word(draw_axis(level[0]), draw_axis(level[1]),
                                   draw_axis(level[2])));
    end

    while (sample_q.size() > 0 || s_vld || mean_q.size() > 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("trimmed_window_mean_filter test passed");
    end else begin
      $display("trimmed_window_mean_filter test failed");
    end
    $finish;
  end

endmodule
